[hw/rtl/fba_pkg.sv]
// shared constants, types and helpers for the fit block allocator
`timescale 1ns / 1ps
package fba_pkg;

    localparam int BLOCKS     = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W      = 5;
    localparam int BLK_W      = 4;
    localparam int VAL_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_MODE    = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_REQ  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_ALLOC  = 2'd1,
        ST_NONE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [IDX_W-1:0]     t_idx;

    // search candidate handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  found;
        t_idx  idx;
        t_size size;
    } t_cand;

    // broadcast from the controller to every cell
    typedef struct packed {
        t_size            req;
        logic             fit_mode;
        logic [CNT_W-1:0] count;
        logic             wr_en;
        t_idx             wr_idx;
        t_size            wr_data;
    } t_cmd;

    function automatic t_size f_to_size(input logic [VAL_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[SIZE_BITS-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] f_to_val(input t_size s);
        logic [31:0] w;
        w = 32'(s);
        return w[VAL_W-1:0];
    endfunction

    function automatic logic [BLK_W-1:0] f_idx_to_blk(input t_idx i);
        logic [31:0] w;
        w = 32'(i);
        return w[BLK_W-1:0];
    endfunction

    function automatic t_idx f_blk_to_idx(input logic [BLK_W-1:0] b);
        logic [31:0] w;
        w = 32'(b);
        return w[IDX_W-1:0];
    endfunction

endpackage

[hw/rtl/fba_if.sv]
// valid/ready channel interfaces for items, results and register writes
`timescale 1ns / 1ps
interface fba_in_if import fba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [BLK_W-1:0] block_index;
    logic [VAL_W-1:0] size_value;

    modport source (output valid, output opcode, output block_index, output size_value,
                    input ready);
    modport sink   (input valid, input opcode, input block_index, input size_value,
                    output ready);
endinterface

interface fba_out_if import fba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [BLK_W-1:0] chosen_block;
    logic [VAL_W-1:0] remaining_size;

    modport source (output valid, output status, output chosen_block, output remaining_size,
                    input ready);
    modport sink   (input valid, input status, input chosen_block, input remaining_size,
                    output ready);
endinterface

interface fba_cfg_if import fba_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/fba_cell.sv]
// one table cell: holds a block's free size and updates the passing candidate
`timescale 1ns / 1ps
module fba_cell import fba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_idx  i_cell_idx,
    input  t_cmd  i_cmd,
    input  t_cand i_cand,
    output t_cand o_cand
);

    t_size r_size;
    t_cand r_cand;
    t_cand n_cand;
    logic  w_active;
    logic  w_fits;
    logic  w_take;

    always_comb begin
        w_active = 32'(i_cell_idx) < 32'(i_cmd.count);
        w_fits   = w_active && (r_size >= i_cmd.req);
        // best fit replaces only on a strictly smaller size, so lower index wins a tie
        w_take   = w_fits && (!i_cand.found || (i_cmd.fit_mode && (r_size < i_cand.size)));
        n_cand   = i_cand;
        if (w_take) begin
            n_cand.found = 1'b1;
            n_cand.idx   = i_cell_idx;
            n_cand.size  = r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size       <= '0;
            r_cand.valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en && (i_cmd.wr_idx == i_cell_idx)) begin
                r_size <= i_cmd.wr_data;
            end
            r_cand.valid <= i_cand.valid;
        end
        r_cand.found <= n_cand.found;
        r_cand.idx   <= n_cand.idx;
        r_cand.size  <= n_cand.size;
    end

    assign o_cand = r_cand;

endmodule

[hw/rtl/fba_ctrl.sv]
// sequencer: takes items, launches the search, writes back and holds the result beat
`timescale 1ns / 1ps
module fba_ctrl import fba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fba_in_if.sink           i_in,
    fba_out_if.source        o_out,
    input  logic             i_fit_mode,
    input  logic [CNT_W-1:0] i_block_count,
    input  t_cand            i_cand,
    output t_cand            o_cand,
    output t_cmd             o_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic             r_op;
    t_size            r_req;
    logic [BLK_W-1:0] r_load_idx;
    logic             r_first;
    logic             r_found;
    t_idx             r_best_idx;
    t_size            r_best_size;

    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [BLK_W-1:0] r_out_chosen;
    logic [VAL_W-1:0] r_out_rem;
    logic [1:0]       n_out_status;
    logic [BLK_W-1:0] n_out_chosen;
    logic [VAL_W-1:0] n_out_rem;

    logic             w_accept;
    logic             w_out_free;
    logic             w_finish;
    logic             w_load_ok;
    t_size            w_new_size;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.opcode == OP_REQ) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_cand.valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        w_finish   = (r_state == S_DONE) && w_out_free;
        w_load_ok  = 32'(r_load_idx) < BLOCKS;
        w_new_size = r_best_size - r_req;

        o_cand.valid = r_first;
        o_cand.found = 1'b0;
        o_cand.idx   = '0;
        o_cand.size  = '0;

        o_cmd.req      = r_req;
        o_cmd.fit_mode = i_fit_mode;
        o_cmd.count    = i_block_count;
        if (r_op == OP_LOAD) begin
            o_cmd.wr_en   = w_finish && w_load_ok;
            o_cmd.wr_idx  = f_blk_to_idx(r_load_idx);
            o_cmd.wr_data = r_req;
            n_out_status  = ST_LOADED;
            n_out_chosen  = r_load_idx;
            n_out_rem     = w_load_ok ? f_to_val(r_req) : '0;
        end else begin
            o_cmd.wr_en   = w_finish && r_found;
            o_cmd.wr_idx  = r_best_idx;
            o_cmd.wr_data = w_new_size;
            n_out_status  = r_found ? ST_ALLOC : ST_NONE;
            n_out_chosen  = r_found ? f_idx_to_blk(r_best_idx) : '0;
            n_out_rem     = r_found ? f_to_val(w_new_size) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= w_accept && (i_in.opcode == OP_REQ);
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_op       <= i_in.opcode;
            r_req      <= f_to_size(i_in.size_value);
            r_load_idx <= i_in.block_index;
        end
        if ((r_state == S_SCAN) && i_cand.valid) begin
            r_found     <= i_cand.found;
            r_best_idx  <= i_cand.idx;
            r_best_size <= i_cand.size;
        end
        if (w_finish) begin
            r_out_status <= n_out_status;
            r_out_chosen <= n_out_chosen;
            r_out_rem    <= n_out_rem;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.chosen_block   = r_out_chosen;
    assign o_out.remaining_size = r_out_rem;

endmodule

[hw/rtl/fit_block_allocator_core.sv]
// top level: register port, sequencer and the row of block cells
// a load's result goes straight to the done state; a request's waits while the
// candidate walks the row of cells, one cell per cycle, back to the sequencer
// one item is in flight at a time; the next can be taken in the same cycle as the
// result first shows in the output register, even if that beat has not yet been taken
// synchronous active-low reset clears all block sizes to zero, selects first
// fit and sets the block count to 16
`timescale 1ns / 1ps
module fit_block_allocator_core import fba_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fba_cfg_if.sink   i_cfg,
    fba_in_if.sink    i_in,
    fba_out_if.source o_out
);

    logic             r_fit_mode;
    logic [CNT_W-1:0] r_block_count;
    t_cmd             w_cmd;
    t_cand            w_cand [BLOCKS+1];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= 1'b0;
            r_block_count <= BLOCK_COUNT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FIT_MODE:    r_fit_mode    <= i_cfg.data[0];
                CFG_BLOCK_COUNT: r_block_count <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    fba_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_fit_mode    (r_fit_mode),
        .i_block_count (r_block_count),
        .i_cand        (w_cand[BLOCKS]),
        .o_cand        (w_cand[0]),
        .o_cmd         (w_cmd)
    );

    for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
        fba_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_cmd      (w_cmd),
            .i_cand     (w_cand[g]),
            .o_cand     (w_cand[g+1])
        );
    end

endmodule

[hw/rtl/fba_chk.sv]
// port-level checks for the allocator, bound to the top level
`timescale 1ns / 1ps
module fba_chk import fba_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       i_status,
    input logic [BLK_W-1:0] i_chosen,
    input logic [VAL_W-1:0] i_rem
);

    // a result beat held back keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_chosen) && $stable(i_rem))
        else $error("result beat changed while stalled");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_LOADED || i_status == ST_ALLOC ||
                         i_status == ST_NONE))
        else $error("undefined status code");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_NONE) |-> (i_chosen == '0) && (i_rem == '0))
        else $error("refused request reports a block");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

endmodule

bind fit_block_allocator_core fba_chk u_fba_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_chosen    (o_out.chosen_block),
    .i_rem       (o_out.remaining_size)
);

[dv/tb_top.sv]
// self-checking testbench for the first-fit / best-fit block allocator
`timescale 1ns / 1ps
module tb_top import fba_pkg::*; ();

    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fba_cfg_if u_cfg_if ();
    fba_in_if  u_in_if ();
    fba_out_if u_out_if ();

    fit_block_allocator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (u_cfg_if),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    typedef struct packed {
        t_status          status;
        logic [BLK_W-1:0] blk;
        logic [VAL_W-1:0] rem;
    } t_reply;

    class fit_predictor;
        t_size            free_sz [BLOCKS];
        logic             best_fit;
        logic [CNT_W-1:0] span;
        t_reply           awaited_replies [$];
        int               mismatches;

        function new();
            foreach (free_sz[i]) free_sz[i] = '0;
            best_fit   = 1'b0;
            span       = BLOCK_COUNT_RST;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FIT_MODE:    best_fit = data[0];
                CFG_BLOCK_COUNT: span = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_item(t_op op, logic [BLK_W-1:0] blk, logic [VAL_W-1:0] val);
            t_reply r;
            t_size  want;
            int     limit;
            int     j;
            int     pick;
            bit     found;
            want = val;
            if (op == OP_LOAD) begin
                r.status = ST_LOADED;
                r.blk    = blk;
                r.rem    = '0;
                if (int'(blk) < BLOCKS) begin
                    free_sz[blk] = want;
                    r.rem        = want;
                end
            end else begin
                limit = (int'(span) > BLOCKS) ? BLOCKS : int'(span);
                found = 1'b0;
                pick  = 0;
                for (j = 0; j < limit; j++) begin
                    if (free_sz[j] >= want) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = j;
                            if (!best_fit) break;
                        end else if (free_sz[j] < free_sz[pick]) begin
                            pick = j;
                        end
                    end
                end
                if (found) begin
                    free_sz[pick] = free_sz[pick] - want;
                    r.status      = ST_ALLOC;
                    r.blk         = BLK_W'(pick);
                    r.rem         = free_sz[pick];
                end else begin
                    r.status = ST_NONE;
                    r.blk    = '0;
                    r.rem    = '0;
                end
            end
            awaited_replies.push_back(r);
        endfunction

        task flag_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_reply(logic [1:0] st, logic [BLK_W-1:0] blk, logic [VAL_W-1:0] rem);
            t_reply e;
            if (awaited_replies.size() == 0) begin
                flag_mismatch("result beat with nothing outstanding");
                return;
            end
            e = awaited_replies.pop_front();
            if (st !== e.status)
                flag_mismatch($sformatf("status %0d, want %0d", st, e.status));
            if (blk !== e.blk)
                flag_mismatch($sformatf("chosen_block %0d, want %0d", blk, e.blk));
            if (rem !== e.rem)
                flag_mismatch($sformatf("remaining_size %0d, want %0d", rem, e.rem));
        endtask

        function int pending();
            return awaited_replies.size();
        endfunction
    endclass

    fit_predictor alloc_model;
    bit           steady = 1'b0;
    int           stall_left = 0;

    // mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return $urandom_range(1, 2);
        if (r < 18) return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_size(int common_max);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2, 3:    return VAL_W'($urandom);
            default: return VAL_W'($urandom_range(0, common_max));
        endcase
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            u_out_if.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            u_out_if.ready <= 1'b0;
            stall_left     <= gap_len() - 1;
        end else begin
            u_out_if.ready <= 1'b1;
        end
    end

    // beats are sampled before this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (u_out_if.valid && u_out_if.ready)
                alloc_model.check_reply(u_out_if.status, u_out_if.chosen_block,
                                        u_out_if.remaining_size);
            if (u_in_if.valid && u_in_if.ready)
                alloc_model.take_item(t_op'(u_in_if.opcode), u_in_if.block_index,
                                      u_in_if.size_value);
            if (u_cfg_if.valid && u_cfg_if.ready)
                alloc_model.write_reg(t_cfg_reg'(u_cfg_if.index), u_cfg_if.data);
        end
    end

    task automatic send_item(t_op op, logic [BLK_W-1:0] blk, logic [VAL_W-1:0] val);
        int g;
        u_in_if.valid       <= 1'b1;
        u_in_if.opcode      <= op;
        u_in_if.block_index <= blk;
        u_in_if.size_value  <= val;
        do @(posedge i_clk); while (!(u_in_if.valid && u_in_if.ready));
        // valid stays up when the next beat follows straight on
        g = steady ? 0 : (($urandom_range(0, 2) == 0) ? gap_len() : 0);
        if (g > 0) begin
            u_in_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        u_cfg_if.valid <= 1'b1;
        u_cfg_if.index <= idx;
        u_cfg_if.data  <= data;
        do @(posedge i_clk); while (!(u_cfg_if.valid && u_cfg_if.ready));
        u_cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic drain();
        u_in_if.valid <= 1'b0;
        do @(negedge i_clk); while (alloc_model.pending() != 0);
        @(posedge i_clk);
    endtask

    task automatic set_phase(logic fit, logic [CNT_W-1:0] cnt);
        drain();
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(fit));
        write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(cnt));
    endtask

    initial begin
        int               ph;
        int               n;
        int               plen;
        int               n_act;
        int               b;
        logic [CNT_W-1:0] cnt;
        logic             fit;
        logic [BLK_W-1:0] blk;

        alloc_model = new();
        i_rst_n             <= 1'b0;
        u_in_if.valid       <= 1'b0;
        u_in_if.opcode      <= OP_LOAD;
        u_in_if.block_index <= '0;
        u_in_if.size_value  <= '0;
        u_cfg_if.valid      <= 1'b0;
        u_cfg_if.index      <= CFG_FIT_MODE;
        u_cfg_if.data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: first fit over all blocks, table empty
        send_item(OP_REQ, 4'd9, 16'd0);       // zero-size request on an empty table
        send_item(OP_REQ, 4'd0, 16'd1);
        send_item(OP_LOAD, 4'd0, 16'hFFFF);
        send_item(OP_LOAD, 4'd15, 16'h8000);
        send_item(OP_LOAD, 4'd5, 16'd100);
        send_item(OP_LOAD, 4'd7, 16'd100);
        send_item(OP_REQ, 4'd15, 16'hFFFF);
        send_item(OP_REQ, 4'd0, 16'd50);

        set_phase(1'b1, 5'd16);
        send_item(OP_LOAD, 4'd3, 16'd200);
        send_item(OP_LOAD, 4'd9, 16'd200);
        send_item(OP_REQ, 4'd0, 16'd150);     // equal sizes, lower index wins
        send_item(OP_REQ, 4'd0, 16'd50);

        set_phase(1'b1, 5'd0);
        send_item(OP_REQ, 4'd0, 16'd0);

        set_phase(1'b1, 5'd31);               // clamps to the table size
        send_item(OP_REQ, 4'd0, 16'h7000);

        set_phase(1'b0, 5'd1);
        send_item(OP_LOAD, 4'd10, 16'd500);   // outside the searched range
        send_item(OP_REQ, 4'd0, 16'd400);
        send_item(OP_REQ, 4'd0, 16'd0);

        set_phase(1'b0, 5'd16);
        send_item(OP_REQ, 4'd0, 16'd400);
        send_item(OP_LOAD, 4'd15, 16'hFFFF);
        send_item(OP_REQ, 4'd0, 16'h8000);

        for (ph = 0; ph < 12; ph++) begin
            case (ph)
                0:       begin cnt = 5'd16; fit = 1'b0; end
                1:       begin cnt = 5'd1;  fit = 1'b1; end
                2:       begin cnt = 5'd31; fit = 1'b1; end
                3:       begin cnt = 5'd0;  fit = 1'b0; end
                default: begin
                    cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(17, 31))
                                                      : CNT_W'($urandom_range(2, 16));
                    fit = 1'($urandom_range(0, 1));
                end
            endcase
            steady = (ph % 4 == 1);
            set_phase(fit, cnt);
            n_act = (int'(cnt) > BLOCKS) ? BLOCKS : int'(cnt);
            plen  = (cnt == 0) ? 40 : 165;

            // fill the searched blocks first so requests have something to hit
            for (b = 0; b < n_act; b++)
                send_item(OP_LOAD, BLK_W'(b), pick_size(1023));

            for (n = 0; n < plen; n++) begin
                if ($urandom_range(0, 9) < 3) begin
                    blk = (n_act > 0 && $urandom_range(0, 4) != 0)
                          ? BLK_W'($urandom_range(0, n_act - 1))
                          : BLK_W'($urandom_range(0, BLOCKS - 1));
                    send_item(OP_LOAD, blk, pick_size(1023));
                end else begin
                    send_item(OP_REQ, BLK_W'($urandom_range(0, BLOCKS - 1)), pick_size(300));
                end
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
        end

        drain();
        repeat (BLOCKS + 4) @(posedge i_clk);
        if (alloc_model.pending() != 0)
            alloc_model.flag_mismatch("results still outstanding at the end");
        if (alloc_model.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
